// File: hw/rtl/nearest_label_address_table_assert.svh
// Assertion macros for the table's RTL; only nlat_engine.sv includes them.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef NEAREST_LABEL_ADDRESS_TABLE_ASSERT_SVH
`define NEAREST_LABEL_ADDRESS_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define NLAT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define NLAT_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define NLAT_ASSERT(name, prop, msg)
`define NLAT_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// File: hw/rtl/nlat_pkg.sv
package nlat_pkg;

  // Request modes.
  localparam logic [1:0] ModeClear  = 2'd0;
  localparam logic [1:0] ModeInsert = 2'd1;
  localparam logic [1:0] ModeLookup = 2'd2;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [15:0] label;
    logic [15:0] addr;
  } entry_t;

  // One result, laid out so that found sits in the lowest bit.
  typedef struct packed {
    logic        table_full;
    logic [15:0] found_label;
    logic [15:0] offset;
    logic        found;
  } res_t;

endpackage

// File: hw/rtl/nearest_label_address_table.sv
// Nearest label address table. It keeps an ascending list of up to CAPACITY distinct 16-bit
// addresses, each with the label id it was first inserted with, in a single synchronous memory
// with one write and one read port. A request on the slave stream carries the mode in tuser
// (clear, insert or lookup) and the address and label in tdata; each request gives exactly one
// result on the master stream. Both insert and lookup run a binary search that probes one
// memory entry per cycle. An insert then moves every stored entry above the new one up one
// place through the memory port and writes the new entry. There is no clearing pass after
// reset: only entries below the count are read. One request is in flight at a time; a
// finished result waits in an output register while the next request is taken.
module nearest_label_address_table #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] address, [31:16] label_id
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] found, [16:1] offset, [32:17] found_label,
                                     // [33] table_full, [39:34] zero
);
  import nlat_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic out_valid_q;
  res_t out_q;

  // The search and insert sequencer owns every access to the memory.
  nlat_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .key_i       (s_axis_tdata[15:0]),
    .label_i     (s_axis_tdata[31:16]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  nlat_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result whenever it is empty or being emptied.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

endmodule

// File: hw/rtl/nlat_ram.sv
module nlat_ram #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  nlat_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output nlat_pkg::entry_t rdata_o
);
  import nlat_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/nlat_engine.sv
module nlat_engine #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [15:0]      key_i,
  input  logic [15:0]      label_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output nlat_pkg::res_t   res_o,
  output logic             ram_we_o,
  output logic [IW-1:0]    ram_waddr_o,
  output nlat_pkg::entry_t ram_wdata_o,
  output logic             ram_re_o,
  output logic [IW-1:0]    ram_raddr_o,
  input  nlat_pkg::entry_t ram_rdata_i
);
  import nlat_pkg::*;

  `include "nearest_label_address_table_assert.svh"

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSearch = 6'b000010,
    StFinish = 6'b000100,
    StShift  = 6'b001000,
    StPut    = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    mode_q, mode_d;
  logic [15:0]   key_q, key_d;
  logic [15:0]   label_q, label_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [IW-1:0] wr_idx_q, wr_idx_d;
  entry_t        best_q, best_d;
  logic          best_vld_q, best_vld_d;
  res_t          res_q, res_d;

  logic          accept;
  logic          cmp_le;
  logic [CW-1:0] lo_n, hi_n, mid_n, mid0, cnt_m1;
  logic [IW-1:0] wr_m1, wr_m2;
  logic          present;

  assign req_ready_o = (state_q == StIdle);
  assign accept      = req_valid_i && req_ready_o;
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

  // The probed entry lies at or below the key: the answer is there or to its right.
  assign cmp_le  = (ram_rdata_i.addr <= key_q);
  assign lo_n    = cmp_le ? (CW'(mid_q) + CW'(1)) : lo_q;
  assign hi_n    = cmp_le ? hi_q : CW'(mid_q);
  assign mid_n   = lo_n + ((hi_n - lo_n) >> 1);
  assign mid0    = count_q >> 1;
  assign cnt_m1  = count_q - CW'(1);
  assign wr_m1   = wr_idx_q - IW'(1);
  assign wr_m2   = wr_idx_q - IW'(2);
  assign present = best_vld_q && (best_q.addr == key_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mode_d      = mode_q;
    key_d       = key_q;
    label_d     = label_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    wr_idx_d    = wr_idx_q;
    best_d      = best_q;
    best_vld_d  = best_vld_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          mode_d     = mode_i;
          key_d      = key_i;
          label_d    = label_i;
          lo_d       = '0;
          hi_d       = count_q;
          best_vld_d = 1'b0;
          res_d      = '0;
          case (mode_i)
            ModeClear: begin
              count_d = '0;
              state_d = StDone;
            end
            ModeInsert, ModeLookup: begin
              if (count_q != '0) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = mid0[IW-1:0];
                mid_d       = mid0[IW-1:0];
                state_d     = StSearch;
              end else begin
                state_d = StFinish;
              end
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end

      StSearch: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (cmp_le) begin
          best_d     = ram_rdata_i;
          best_vld_d = 1'b1;
        end
        if (lo_n < hi_n) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = mid_n[IW-1:0];
          mid_d       = mid_n[IW-1:0];
        end else begin
          state_d = StFinish;
        end
      end

      StFinish: begin
        if (mode_q == ModeLookup) begin
          if (best_vld_q) begin
            res_d.found       = 1'b1;
            res_d.offset      = key_q - best_q.addr;
            res_d.found_label = best_q.label;
          end else begin
            res_d.offset = key_q;
          end
          state_d = StDone;
        end else if (present) begin
          state_d = StDone;
        end else if (count_q >= CW'(CAPACITY)) begin
          res_d.table_full = 1'b1;
          state_d          = StDone;
        end else if (lo_q == count_q) begin
          state_d = StPut;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = cnt_m1[IW-1:0];
          wr_idx_d    = count_q[IW-1:0];
          state_d     = StShift;
        end
      end

      StShift: begin
        // Entry wr_idx-1 has arrived; move it up one place and fetch the next one down.
        ram_we_o    = 1'b1;
        ram_waddr_o = wr_idx_q;
        ram_wdata_o = ram_rdata_i;
        if (wr_m1 == lo_q[IW-1:0]) begin
          state_d = StPut;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = wr_m2;
          wr_idx_d    = wr_m1;
        end
      end

      StPut: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = lo_q[IW-1:0];
        ram_wdata_o = '{label: label_q, addr: key_q};
        count_d     = count_q + CW'(1);
        state_d     = StDone;
      end

      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    key_q      <= key_d;
    label_q    <= label_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    wr_idx_q   <= wr_idx_d;
    best_q     <= best_d;
    best_vld_q <= best_vld_d;
    res_q      <= res_d;
  end

  `NLAT_ASSERT_NEVER(a_rw_clash, ram_re_o && ram_we_o && (ram_raddr_o == ram_waddr_o), "read and write hit one entry")
  `NLAT_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `NLAT_ASSERT(a_shift_above_pos, (state_q == StShift) |-> (CW'(wr_idx_q) > lo_q), "shift below insert position")
  `NLAT_ASSERT(a_accept_busy, accept |=> (state_q != StIdle), "accepted request did not start")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import nlat_pkg::*;

  localparam int unsigned Capacity = 1024;
  // Mode three has no meaning and must leave the table alone.
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned RandomRequests = 400;
  // At or above this size the random part starts to clear the table, so that inserts, which move
  // every larger entry up one place, stay cheap.
  localparam int unsigned RandomSizeCap = 150;
  localparam int unsigned FullProbeRequests = 60;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [15:0] label;
    logic        typed;  // the row carries its own expected result
    res_t        res;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [15:0] address, [31:16] label_id
  logic [1:0]  s_axis_tuser = ModeClear;  // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // [0] found, [16:1] offset, [32:17] found_label, [33] table_full

  // Shadow copy of the table, kept in step with every accepted request.
  logic [15:0] shadow_addr [Capacity];
  logic [15:0] shadow_label [Capacity];
  int unsigned shadow_count = 0;

  res_t          pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  // While set, neither the request side nor the result side inserts idle cycles.
  bit            steady = 1'b0;

  nearest_label_address_table #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a run that hangs or crawls ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] wanted);
    $display("mismatch in %s at cycle %0d: got %h, wanted %h", what, cycle_count, got, wanted);
    mismatch_count++;
  endtask

  // Index of the first stored address that is not below the key, or the count if none is.
  function automatic int unsigned first_not_below(input logic [15:0] key);
    int unsigned lo = 0;
    int unsigned hi = shadow_count;
    int unsigned mid;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (shadow_addr[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // Applies one request to the shadow table and returns the result the block should give.
  function automatic res_t predict_request(input logic [1:0] mode, input logic [15:0] addr,
                                           input logic [15:0] label);
    res_t res = '0;
    int unsigned pos;
    pos = first_not_below(addr);
    case (mode)
      ModeClear: begin
        shadow_count = 0;
      end
      ModeInsert: begin
        // A repeated address keeps its first label and is never flagged, full or not.
        if (!(pos < shadow_count && shadow_addr[pos] == addr)) begin
          if (shadow_count >= Capacity) begin
            res.table_full = 1'b1;
          end else begin
            for (int unsigned i = shadow_count; i > pos; i--) begin
              shadow_addr[i] = shadow_addr[i - 1];
              shadow_label[i] = shadow_label[i - 1];
            end
            shadow_addr[pos] = addr;
            shadow_label[pos] = label;
            shadow_count++;
          end
        end
      end
      ModeLookup: begin
        // Nothing at or below the query: not found, and the offset is the query itself.
        res.offset = addr;
        if (pos < shadow_count && shadow_addr[pos] == addr) begin
          res.found = 1'b1;
          res.offset = '0;
          res.found_label = shadow_label[pos];
        end else if (pos > 0) begin
          res.found = 1'b1;
          res.offset = addr - shadow_addr[pos - 1];
          res.found_label = shadow_label[pos - 1];
        end
      end
      default: begin
        // The unused mode changes nothing and answers with all fields zero.
      end
    endcase
    return res;
  endfunction

  // Offers one request, waits for it to be taken and queues the result it should give. The
  // valid line stays high between back-to-back requests.
  task automatic send_request(input logic [1:0] mode, input logic [15:0] addr,
                              input logic [15:0] label, input logic typed = 1'b0,
                              input res_t typed_res = '0);
    int unsigned gap;
    res_t predicted;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {label, addr};
    s_axis_tuser <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_request(mode, addr, label);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
  endtask

  function automatic directed_row_t make_row(input logic [1:0] mode, input logic [15:0] addr,
                                             input logic [15:0] label, input logic typed = 1'b0,
                                             input logic found = 1'b0,
                                             input logic [15:0] offset = '0,
                                             input logic [15:0] found_label = '0,
                                             input logic table_full = 1'b0);
    directed_row_t row;
    row.mode = mode;
    row.addr = addr;
    row.label = label;
    row.typed = typed;
    row.res.found = found;
    row.res.offset = offset;
    row.res.found_label = found_label;
    row.res.table_full = table_full;
    return row;
  endfunction

  // Appends one row to the directed table.
  task automatic queue_row(input directed_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // A mixed request with addresses drawn towards the extremes and towards stored entries, so
  // that lookups hit exactly, land just above or below entries, and inserts often repeat.
  task automatic send_random_request();
    int unsigned roll;
    int unsigned pick;
    logic [1:0]  mode;
    logic [15:0] addr;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      mode = ModeClear;
    end else if (roll < 4) begin
      mode = ModeUnused;
    end else if (roll < 52) begin
      mode = ModeInsert;
    end else begin
      mode = ModeLookup;
    end
    pick = $urandom_range(0, 5);
    if (shadow_count == 0 && pick >= 1 && pick <= 3) begin
      pick = 5;
    end
    case (pick)
      0: addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1, 2: addr = shadow_addr[$urandom_range(0, shadow_count - 1)];
      3: addr = shadow_addr[$urandom_range(0, shadow_count - 1)]
                + 16'($urandom_range(0, 128)) - 16'd64;
      default: addr = 16'($urandom());
    endcase
    send_request(mode, addr, 16'($urandom()));
  endtask

  initial begin : stimulus
    int unsigned fill_at;
    int unsigned pos;
    int unsigned pick;
    logic [15:0] addr;

    // Directed requests. Rows with a typed result can be read off at a glance; the others are
    // left to the shadow table.
    queue_row(make_row(ModeLookup, 16'h0000, 16'h1111, 1'b1, 1'b0, 16'h0000));
    queue_row(make_row(ModeLookup, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF));
    queue_row(make_row(ModeUnused, 16'hFFFF, 16'hFFFF, 1'b1));
    queue_row(make_row(ModeInsert, 16'h8000, 16'hAAAA, 1'b1));
    // Repeated address: the first label must survive.
    queue_row(make_row(ModeInsert, 16'h8000, 16'h5555, 1'b1));
    queue_row(make_row(ModeLookup, 16'h8000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'hAAAA));
    // Just below the smallest entry.
    queue_row(make_row(ModeLookup, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 16'h7FFF));
    queue_row(make_row(ModeLookup, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h7FFF, 16'hAAAA));
    queue_row(make_row(ModeInsert, 16'h0000, 16'hFFFF, 1'b1));
    queue_row(make_row(ModeInsert, 16'hFFFF, 16'h0000, 1'b1));
    queue_row(make_row(ModeLookup, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'hFFFF));
    queue_row(make_row(ModeLookup, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000));
    queue_row(make_row(ModeLookup, 16'h7FFF, 16'h0000));
    queue_row(make_row(ModeInsert, 16'h1234, 16'h0F0F));
    queue_row(make_row(ModeInsert, 16'h4000, 16'hF0F0));
    queue_row(make_row(ModeLookup, 16'h1235, 16'hFFFF));
    queue_row(make_row(ModeLookup, 16'h3FFF, 16'h0000));
    queue_row(make_row(ModeUnused, 16'h4000, 16'h1234, 1'b1));
    queue_row(make_row(ModeLookup, 16'h4001, 16'h0000));
    queue_row(make_row(ModeClear, 16'h0000, 16'h0000, 1'b1));
    // After a clear the table is empty again.
    queue_row(make_row(ModeLookup, 16'h8000, 16'h0000, 1'b1, 1'b0, 16'h8000));
    queue_row(make_row(ModeInsert, 16'h0001, 16'h0001, 1'b1));
    queue_row(make_row(ModeLookup, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000));
    queue_row(make_row(ModeLookup, 16'h0002, 16'h0000));
    queue_row(make_row(ModeClear, 16'hFFFF, 16'hFFFF, 1'b1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].label,
                   directed_rows[i].typed, directed_rows[i].res);
    end

    fill_at = $urandom_range(100, 300);
    for (int unsigned n = 0; n < RandomRequests; n++) begin
      if (n % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (n == fill_at) begin
        // Fill the table to capacity with rising addresses, so that each insert lands at the
        // top and nothing has to move, then work on the full table for a while.
        send_request(ModeClear, 16'($urandom()), 16'($urandom()));
        addr = 16'($urandom_range(0, 1000));
        repeat (Capacity) begin
          send_request(ModeInsert, addr, 16'($urandom()));
          addr = addr + 16'($urandom_range(1, 63));
        end
        repeat (FullProbeRequests) begin
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            // A new address must be dropped and flagged.
            do begin
              addr = 16'($urandom());
              pos = first_not_below(addr);
            end while (pos < shadow_count && shadow_addr[pos] == addr);
            send_request(ModeInsert, addr, 16'($urandom()));
          end else if (pick == 1) begin
            // A repeated address is not flagged even though the table is full.
            send_request(ModeInsert, shadow_addr[$urandom_range(0, Capacity - 1)],
                         16'($urandom()));
          end else begin
            send_request(ModeLookup, 16'($urandom()), 16'($urandom()));
          end
        end
        send_request(ModeLookup, 16'h0000, 16'($urandom()));
        send_request(ModeLookup, 16'hFFFF, 16'($urandom()));
        send_request(ModeClear, 16'($urandom()), 16'($urandom()));
      end
      if (shadow_count >= RandomSizeCap && $urandom_range(0, 3) == 0) begin
        send_request(ModeClear, 16'($urandom()), 16'($urandom()));
      end
      send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: unless steady is set, holds tready low for a random stall before each result,
  // then compares every field with the oldest outstanding expectation.
  initial begin : result_sink
    int unsigned stall;
    res_t got;
    res_t wanted;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", m_axis_tdata, '0);
      end else begin
        wanted = pending_results.pop_front();
        got = res_t'(m_axis_tdata[33:0]);
        if (got.found !== wanted.found) begin
          report_mismatch("found", 40'(got.found), 40'(wanted.found));
        end
        if (got.offset !== wanted.offset) begin
          report_mismatch("offset", 40'(got.offset), 40'(wanted.offset));
        end
        if (got.found_label !== wanted.found_label) begin
          report_mismatch("found_label", 40'(got.found_label), 40'(wanted.found_label));
        end
        if (got.table_full !== wanted.table_full) begin
          report_mismatch("table_full", 40'(got.table_full), 40'(wanted.table_full));
        end
        if (m_axis_tdata[39:34] !== '0) begin
          report_mismatch("padding", 40'(m_axis_tdata[39:34]), '0);
        end
      end
    end
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/nlat_pkg.sv
hw/rtl/nlat_ram.sv
hw/rtl/nlat_engine.sv
hw/rtl/nearest_label_address_table.sv
tb/sv/tb.sv
